### hdl/text_terminal_writer_defines.svh
// ----------------------------------------------------------------------------
// text_terminal_writer_defines.svh
// Assertion macros shared by the terminal writer RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_WRITER_DEFINES_SVH
`define TEXT_TERMINAL_WRITER_DEFINES_SVH

// Check a property on clk, held off while arst_n is low.
`define TTW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds.
`define TTW_NEVER(label, expr, msg) \
	`TTW_ASSERT(label, !(expr), msg)

`endif

### hdl/ttw_pkg.sv
// ----------------------------------------------------------------------------
// ttw_pkg
// Geometry, character codes and shared types of the terminal writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttw_pkg;

	// Screen geometry
	localparam int COLUMNS = 40;
	localparam int ROWS    = 24;
	localparam int CELLS   = ROWS * COLUMNS;
	localparam int ADDR_W  = $clog2(CELLS);
	localparam int RW      = $clog2(ROWS);
	localparam int CW      = $clog2(COLUMNS);

	// Field widths at the ports
	localparam int CODE_W  = 8;
	localparam int CHAR_W  = 7;
	localparam int ROW_FW  = 5;
	localparam int COL_FW  = 6;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_CR    = 7'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
	localparam logic [CHAR_W-1:0] CH_TILDE = 7'h7E;
	localparam logic [CHAR_W-1:0] CH_CHECK = 7'h5F;
	localparam logic [CHAR_W-1:0] CH_MARK  = 7'h00;
	localparam logic [CHAR_W-1:0] CH_AT    = 7'h40;
	localparam logic [CHAR_W-1:0] CH_LC_A  = 7'h61;
	localparam logic [CHAR_W-1:0] CH_LC_Z  = 7'h7A;
	localparam logic [CHAR_W-1:0] CASE_STEP = 7'd32;

	// Command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// Screen memory access, addressed by logical row
	typedef struct packed {
		logic              en;
		logic              we;
		logic [RW-1:0]     row;
		logic [CW-1:0]     col;
		logic [CHAR_W-1:0] wdata;
	} scr_req_t;

	// One result transaction
	typedef struct packed {
		logic [CHAR_W-1:0] glyph;
		logic [ROW_FW-1:0] row;
		logic [COL_FW-1:0] col;
	} res_t;

endpackage

`default_nettype wire

### hdl/ttw_req_if.sv
// ----------------------------------------------------------------------------
// ttw_req_if
// Request channel: write a character or read the glyph of one cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ttw_req_if;
	import ttw_pkg::*;

	logic              valid;
	logic              ready;
	logic              cmd;
	logic [CODE_W-1:0] char_code;
	logic [ROW_FW-1:0] cell_row;
	logic [COL_FW-1:0] cell_col;
	logic              blink_phase;

	modport source (
		output valid, cmd, char_code, cell_row, cell_col, blink_phase,
		input  ready
	);
	modport sink (
		input  valid, cmd, char_code, cell_row, cell_col, blink_phase,
		output ready
	);
endinterface

`default_nettype wire

### hdl/ttw_rsp_if.sv
// ----------------------------------------------------------------------------
// ttw_rsp_if
// Response channel: glyph and cursor position after each request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ttw_rsp_if;
	import ttw_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] glyph;
	logic [ROW_FW-1:0] cursor_row_out;
	logic [COL_FW-1:0] cursor_col_out;

	modport source (
		output valid, glyph, cursor_row_out, cursor_col_out,
		input  ready
	);
	modport sink (
		input  valid, glyph, cursor_row_out, cursor_col_out,
		output ready
	);
endinterface

`default_nettype wire

### hdl/ttw_screen.sv
// ----------------------------------------------------------------------------
// ttw_screen
// Character memory with row ring mapping and registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttw_screen (
	input  wire logic                      clk,
	input  wire ttw_pkg::scr_req_t         req,
	input  wire logic [ttw_pkg::RW-1:0]    top,
	output logic [ttw_pkg::CHAR_W-1:0]     rdata
);
	import ttw_pkg::*;

	localparam int SW = RW + 1;

	logic [CHAR_W-1:0] cells_q [CELLS];
	logic [CHAR_W-1:0] rdata_q;
	logic [SW-1:0]     row_sum;
	logic [RW-1:0]     prow;
	logic [ADDR_W-1:0] addr;

	// Rotate the logical row by the top-row offset
	assign row_sum = {1'b0, req.row} + {1'b0, top};
	assign prow = (row_sum >= SW'(ROWS)) ? RW'(row_sum - SW'(ROWS)) : RW'(row_sum);
	assign addr = ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(req.col);

	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				cells_q[addr] <= req.wdata;
			end else begin
				rdata_q <= cells_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### hdl/ttw_seq.sv
// ----------------------------------------------------------------------------
// ttw_seq
// Sequencer: reset fill, cursor, scroll ring pointer and cell accesses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "text_terminal_writer_defines.svh"

module ttw_seq (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	ttw_req_if.sink                        request,
	output ttw_pkg::scr_req_t              mreq,
	output logic [ttw_pkg::RW-1:0]         top,
	input  wire logic [ttw_pkg::CHAR_W-1:0] rdata,
	output logic                           res_valid,
	output ttw_pkg::res_t                  res,
	input  wire logic                      res_ready
);
	import ttw_pkg::*;

	typedef enum logic [2:0] {
		S_INIT, S_IDLE, S_PUT, S_CLEAR, S_MARK, S_RDWAIT, S_DONE
	} state_t;

	state_t            state_q;
	logic [RW-1:0]     init_row_q;
	logic [CW-1:0]     sweep_col_q;
	logic [RW-1:0]     cur_row_q;
	logic [CW-1:0]     cur_col_q;
	logic [RW-1:0]     top_q;
	logic [CHAR_W-1:0] ch_q;
	logic              cr_q;
	logic              blink_q;
	logic [CHAR_W-1:0] glyph_q;

	logic              acc;
	logic              oob;
	logic [CHAR_W-1:0] ch_in;
	logic [CHAR_W-1:0] ch_fold;
	logic              printable;

	assign request.ready = (state_q == S_IDLE);
	assign acc   = request.valid && request.ready;
	assign oob   = (request.cell_row >= ROWS) || (request.cell_col >= COLUMNS);
	assign ch_in = request.char_code[CHAR_W-1:0];

	always_comb begin
		printable = ch_in inside {[CH_SPACE:CH_TILDE]};
		if (ch_in inside {[CH_LC_A:CH_LC_Z]}) begin
			ch_fold = ch_in - CASE_STEP;
		end else begin
			ch_fold = ch_in;
		end
	end

	// Memory accesses by state
	always_comb begin
		mreq = '0;
		case (state_q)
			S_INIT: begin
				mreq.en    = 1'b1;
				mreq.we    = 1'b1;
				mreq.row   = init_row_q;
				mreq.col   = sweep_col_q;
				mreq.wdata = (init_row_q[0] ^ sweep_col_q[0]) ? CH_CHECK : CH_MARK;
			end
			S_IDLE: begin
				mreq.en  = acc && (request.cmd == CMD_READ) && !oob;
				mreq.row = RW'(request.cell_row);
				mreq.col = CW'(request.cell_col);
			end
			S_PUT: begin
				mreq.en    = 1'b1;
				mreq.we    = 1'b1;
				mreq.row   = cur_row_q;
				mreq.col   = cur_col_q;
				mreq.wdata = ch_q;
			end
			S_CLEAR: begin
				mreq.en    = 1'b1;
				mreq.we    = 1'b1;
				mreq.row   = RW'(ROWS - 1);
				mreq.col   = sweep_col_q;
				mreq.wdata = CH_SPACE;
			end
			S_MARK: begin
				mreq.en    = 1'b1;
				mreq.we    = 1'b1;
				mreq.row   = cur_row_q;
				mreq.col   = cur_col_q;
				mreq.wdata = CH_MARK;
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_row_q  <= '0;
			sweep_col_q <= '0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			top_q       <= '0;
			ch_q        <= '0;
			cr_q        <= 1'b0;
			blink_q     <= 1'b0;
			glyph_q     <= '0;
		end else begin
			case (state_q)
				S_INIT: begin
					if (sweep_col_q == CW'(COLUMNS - 1)) begin
						sweep_col_q <= '0;
						if (init_row_q == RW'(ROWS - 1)) begin
							state_q <= S_IDLE;
						end else begin
							init_row_q <= init_row_q + 1'b1;
						end
					end else begin
						sweep_col_q <= sweep_col_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (acc) begin
						blink_q <= request.blink_phase;
						glyph_q <= ((request.cmd == CMD_READ) && oob) ? CH_SPACE : '0;
						if (request.cmd == CMD_READ) begin
							if (oob) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_RDWAIT;
							end
						end else if (ch_in == CH_CR) begin
							ch_q    <= CH_SPACE;
							cr_q    <= 1'b1;
							state_q <= S_PUT;
						end else if (printable) begin
							ch_q    <= ch_fold;
							cr_q    <= 1'b0;
							state_q <= S_PUT;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_PUT: begin
					if (cr_q || (cur_col_q == CW'(COLUMNS - 1))) begin
						cur_col_q <= '0;
						if (cur_row_q == RW'(ROWS - 1)) begin
							// Scroll: advance the ring, then blank the new bottom row
							top_q       <= (top_q == RW'(ROWS - 1)) ? '0 : top_q + 1'b1;
							sweep_col_q <= '0;
							state_q     <= S_CLEAR;
						end else begin
							cur_row_q <= cur_row_q + 1'b1;
							state_q   <= S_MARK;
						end
					end else begin
						cur_col_q <= cur_col_q + 1'b1;
						state_q   <= S_MARK;
					end
				end
				S_CLEAR: begin
					if (sweep_col_q == CW'(COLUMNS - 1)) begin
						state_q <= S_MARK;
					end else begin
						sweep_col_q <= sweep_col_q + 1'b1;
					end
				end
				S_MARK: begin
					state_q <= S_DONE;
				end
				S_RDWAIT: begin
					if (rdata == CH_MARK) begin
						glyph_q <= blink_q ? CH_AT : CH_SPACE;
					end else begin
						glyph_q <= rdata;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign top       = top_q;
	assign res_valid = (state_q == S_DONE);
	assign res.glyph = glyph_q;
	assign res.row   = ROW_FW'(cur_row_q);
	assign res.col   = COL_FW'(cur_col_q);

	`TTW_NEVER(a_cur_row_range, cur_row_q >= ROWS, "cursor row beyond the last row")
	`TTW_NEVER(a_cur_col_range, cur_col_q >= COLUMNS, "cursor column beyond the last column")
	`TTW_NEVER(a_top_range, top_q >= ROWS, "top-row offset out of range")
	`TTW_ASSERT(a_clear_to_mark,
		(state_q == S_CLEAR && sweep_col_q == CW'(COLUMNS - 1)) |=> (state_q == S_MARK),
		"row blank did not end in a cursor mark")

endmodule

`default_nettype wire

### hdl/text_terminal_writer.sv
// ----------------------------------------------------------------------------
// text_terminal_writer
// 40 x 24 character-cell terminal: character writes and glyph reads.
// ----------------------------------------------------------------------------
//
//  Channel    Direction  Transaction
//  request    sink       cmd, char_code, cell_row, cell_col, blink_phase
//  response   source     glyph, cursor_row_out, cursor_col_out
//
//  One request transaction at a time; the single screen memory port sets the
//  pace. In-range reads wait for registered data, ignored codes write nothing,
//  and a CR or printable character writes its cell, blanks the new bottom row
//  on a scroll, then marks the cursor. After reset a fill pass over ROWS x
//  COLUMNS (960) cells writes the checkerboard; request.ready stays low until
//  it ends. The response register holds one finished result; a new request is
//  taken while it waits; the sequencer holds its next result until it drains.
//
`timescale 1ns / 1ps
`default_nettype none

module text_terminal_writer (
	input  wire logic clk,
	input  wire logic arst_n,
	ttw_req_if.sink   request,
	ttw_rsp_if.source response
);
	import ttw_pkg::*;

	scr_req_t          mreq;
	logic [RW-1:0]     top;
	logic [CHAR_W-1:0] rdata;
	logic              res_valid;
	res_t              res;
	logic              slot_free;
	logic              out_valid_q;
	res_t              out_q;

	// Screen memory: every cell lives here, addressed through the row ring
	ttw_screen u_screen (
		.clk   (clk),
		.req   (mreq),
		.top   (top),
		.rdata (rdata)
	);

	// Sequencer: reset fill, cursor moves, scroll, reads
	ttw_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.mreq      (mreq),
		.top       (top),
		.rdata     (rdata),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (slot_free)
	);

	// Output register: free when empty or being drained this cycle
	assign slot_free = !out_valid_q || response.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= res_valid;
		end
	end

	// Hold the payload until the transaction completes
	always_ff @(posedge clk) begin
		if (slot_free && res_valid) begin
			out_q <= res;
		end
	end

	assign response.valid          = out_valid_q;
	assign response.glyph          = out_q.glyph;
	assign response.cursor_row_out = out_q.row;
	assign response.cursor_col_out = out_q.col;

endmodule

`default_nettype wire
